/* rtl/core/dnd_pkg.sv */
// Shared types, constants and the month table of the day number / date converter.
package dnd_pkg;

    // Pipeline depth and the stage in which the day count result is complete.
    localparam int NSTG     = 9;
    localparam int DAYS_STG = 4;
    localparam int MONTHS   = 12;

    typedef enum logic {
        CMD_TO_DATE = 1'b0,
        CMD_TO_DAYS = 1'b1
    } dnd_cmd_t;

    typedef struct packed {
        logic        command;
        logic [30:0] day_count;
        logic [22:0] in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
    } dnd_req_t;

    typedef struct packed {
        logic [22:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [30:0] out_day_count;
    } dnd_res_t;

    localparam int DAYS_COMMON     = 365;
    localparam int DAYS_4Y_COMMON  = 4 * DAYS_COMMON;
    localparam int DAYS_4Y         = DAYS_4Y_COMMON + 1;
    localparam int DAYS_100Y_FIRST = 100 * DAYS_COMMON + 25;
    localparam int DAYS_100Y       = 100 * DAYS_COMMON + 24;
    localparam int DAYS_400Y       = 400 * DAYS_COMMON + 97;
    localparam int CEN2_START      = DAYS_100Y_FIRST + DAYS_100Y;
    localparam int CEN3_START      = DAYS_100Y_FIRST + 2 * DAYS_100Y;

    // Zero-based day of year (in common-year numbering) of 1 March, and the
    // same point as leap-year month start plus day of month.
    localparam int MARCH_DOY       = 59;
    localparam int MARCH_DD        = 61;
    localparam logic [3:0] MONTH_LAST = 4'd11;

    // Exact reciprocals: floor(n / d) == (n * RECIP) >> SH for the operand
    // widths used in the datapaths.
    localparam int RECIP_400Y_SH = 49;
    localparam logic [31:0] RECIP_400Y =
        32'(((64'd1 << RECIP_400Y_SH) + 64'(DAYS_400Y) - 64'd1) / 64'(DAYS_400Y));
    localparam int RECIP_4Y_SH = 27;
    localparam logic [16:0] RECIP_4Y =
        17'(((64'd1 << RECIP_4Y_SH) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y));
    localparam int RECIP_25_SH = 26;
    localparam logic [21:0] RECIP_25 =
        22'(((64'd1 << RECIP_25_SH) + 64'd24) / 64'd25);

    // Days before the first of each month in a leap year.
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd60;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd121;
            4'd5:    v = 9'd152;
            4'd6:    v = 9'd182;
            4'd7:    v = 9'd213;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd274;
            4'd10:   v = 9'd305;
            default: v = 9'd335;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/dnd_ctrl.sv */
// Valid tracking, stall propagation and stage enables of the converter pipeline.
module dnd_ctrl import dnd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_cmd,
    input  logic            res_stall,
    output logic            req_stall,
    output logic [NSTG-1:0] en,
    output logic            res_valid,
    output logic            res_cmd
);

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] cmd_reg;
    logic [NSTG:0]   ready;

    // A stage may load when it is empty or when the stage after it moves.
    always_comb
    begin
        ready[NSTG] = !res_stall;
        for (int i = NSTG - 1; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    assign en        = ready[NSTG-1:0];
    assign req_stall = !ready[0];
    assign res_valid = valid_reg[NSTG-1];
    assign res_cmd   = cmd_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= req_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (ready[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            cmd_reg[0] <= req_cmd;
        end
        for (int i = 1; i < NSTG; i++)
        begin
            if (ready[i])
            begin
                cmd_reg[i] <= cmd_reg[i-1];
            end
        end
    end

endmodule

/* rtl/core/dnd_to_date.sv */
// Day count to year, month and day datapath, nine register stages.
module dnd_to_date import dnd_pkg::*;
(
    input  logic            clk,
    input  logic [NSTG-1:0] en,
    input  logic [30:0]     day_count,
    output logic [22:0]     year,
    output logic [3:0]      month,
    output logic [4:0]      day
);

    // Stage 0: 400-year cycle count by reciprocal multiply.
    logic [62:0] prod400;
    logic [13:0] s0_q_reg;
    logic [30:0] s0_dc_reg;

    assign prod400 = {32'd0, day_count} * {31'd0, RECIP_400Y};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_q_reg  <= prod400[62:RECIP_400Y_SH];
            s0_dc_reg <= day_count;
        end
    end

    // Stage 1: days in the whole cycles.
    logic [31:0] rprod;
    logic [30:0] s1_rprod_reg;
    logic [13:0] s1_q_reg;
    logic [30:0] s1_dc_reg;

    assign rprod = {18'd0, s0_q_reg} * 32'(DAYS_400Y);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_rprod_reg <= rprod[30:0];
            s1_q_reg     <= s0_q_reg;
            s1_dc_reg    <= s0_dc_reg;
        end
    end

    // Stage 2: day within the cycle, and the year of the cycle start.
    logic [30:0] rem_full;
    logic [22:0] yr400_next;
    logic [17:0] s2_rem_reg;
    logic [22:0] s2_yr_reg;

    assign rem_full   = s1_dc_reg - s1_rprod_reg;
    assign yr400_next = {9'd0, s1_q_reg} * 23'd400;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_rem_reg <= rem_full[17:0];
            s2_yr_reg  <= yr400_next;
        end
    end

    // Stage 3: century within the cycle; the first century is one day longer.
    logic [1:0]  cen_next;
    logic [17:0] cen_base;
    logic [17:0] rem_c_full;
    logic [1:0]  s3_cen_reg;
    logic [15:0] s3_rem_reg;
    logic [22:0] s3_yr_reg;

    always_comb
    begin
        if (s2_rem_reg >= 18'(CEN3_START))
        begin
            cen_next = 2'd3;
            cen_base = 18'(CEN3_START);
        end
        else if (s2_rem_reg >= 18'(CEN2_START))
        begin
            cen_next = 2'd2;
            cen_base = 18'(CEN2_START);
        end
        else if (s2_rem_reg >= 18'(DAYS_100Y_FIRST))
        begin
            cen_next = 2'd1;
            cen_base = 18'(DAYS_100Y_FIRST);
        end
        else
        begin
            cen_next = 2'd0;
            cen_base = 18'd0;
        end
        rem_c_full = s2_rem_reg - cen_base;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_cen_reg <= cen_next;
            s3_rem_reg <= rem_c_full[15:0];
            s3_yr_reg  <= s2_yr_reg;
        end
    end

    // Stage 4: a century that does not start on a 400-year boundary opens
    // with a four-year block that has no leap day.
    logic        adj_next;
    logic        s4_adj_reg;
    logic [1:0]  s4_cen_reg;
    logic [15:0] s4_rem_reg;
    logic [22:0] s4_yr_reg;

    assign adj_next = (s3_cen_reg != 2'd0) && (s3_rem_reg >= 16'(DAYS_4Y_COMMON));

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_adj_reg <= adj_next;
            s4_cen_reg <= s3_cen_reg;
            s4_rem_reg <= adj_next ? s3_rem_reg - 16'(DAYS_4Y_COMMON) : s3_rem_reg;
            s4_yr_reg  <= s3_yr_reg;
        end
    end

    // Stage 5: four-year block count by reciprocal multiply.
    logic [31:0] prod4;
    logic [4:0]  s5_q4_reg;
    logic        s5_adj_reg;
    logic [1:0]  s5_cen_reg;
    logic [15:0] s5_rem_reg;
    logic [22:0] s5_yr_reg;

    assign prod4 = {16'd0, s4_rem_reg} * {15'd0, RECIP_4Y};

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_q4_reg  <= prod4[31:RECIP_4Y_SH];
            s5_adj_reg <= s4_adj_reg;
            s5_cen_reg <= s4_cen_reg;
            s5_rem_reg <= s4_rem_reg;
            s5_yr_reg  <= s4_yr_reg;
        end
    end

    // Stage 6: day within the four-year block. Its first year is common only
    // on a century that is not a 400-year boundary.
    logic [15:0] rem4_full;
    logic [4:0]  k_next;
    logic [8:0]  small_next;
    logic [10:0] s6_rem_reg;
    logic        s6_leap_reg;
    logic [8:0]  s6_small_reg;
    logic [22:0] s6_yr_reg;

    always_comb
    begin
        rem4_full  = s5_rem_reg - {11'd0, s5_q4_reg} * 16'(DAYS_4Y);
        k_next     = s5_q4_reg + {4'd0, s5_adj_reg};
        small_next = {7'd0, s5_cen_reg} * 9'd100 + {2'd0, k_next, 2'd0};
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_rem_reg   <= rem4_full[10:0];
            s6_leap_reg  <= (k_next != 5'd0) || (s5_cen_reg == 2'd0);
            s6_small_reg <= small_next;
            s6_yr_reg    <= s5_yr_reg;
        end
    end

    // Stage 7: single years, then shift common years past 29 February.
    logic [10:0] t1;
    logic [10:0] t2;
    logic [10:0] t3;
    logic [1:0]  yoff;
    logic [10:0] ybase;
    logic [10:0] rem_y_full;
    logic [8:0]  rem_y;
    logic        leap_y;
    logic [8:0]  doy_next;
    logic [8:0]  s7_doy_reg;
    logic [22:0] s7_yr_reg;

    always_comb
    begin
        t1 = 11'(DAYS_COMMON) + {10'd0, s6_leap_reg};
        t2 = 11'(2 * DAYS_COMMON) + {10'd0, s6_leap_reg};
        t3 = 11'(3 * DAYS_COMMON) + {10'd0, s6_leap_reg};
        if (s6_rem_reg >= t3)
        begin
            yoff  = 2'd3;
            ybase = t3;
        end
        else if (s6_rem_reg >= t2)
        begin
            yoff  = 2'd2;
            ybase = t2;
        end
        else if (s6_rem_reg >= t1)
        begin
            yoff  = 2'd1;
            ybase = t1;
        end
        else
        begin
            yoff  = 2'd0;
            ybase = 11'd0;
        end
        rem_y_full = s6_rem_reg - ybase;
        rem_y      = rem_y_full[8:0];
        leap_y     = s6_leap_reg && (yoff == 2'd0);
        doy_next   = rem_y + {8'd0, (!leap_y && (rem_y >= 9'(MARCH_DOY)))};
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_doy_reg <= doy_next;
            s7_yr_reg  <= s6_yr_reg + {14'd0, s6_small_reg} + {21'd0, yoff};
        end
    end

    // Stage 8: month and day of month.
    logic [3:0]  mon_next;
    logic [8:0]  day_full;
    logic [22:0] s8_yr_reg;
    logic [3:0]  s8_mon_reg;
    logic [4:0]  s8_day_reg;

    always_comb
    begin
        mon_next = 4'd0;
        for (int i = 1; i < MONTHS; i++)
        begin
            if (s7_doy_reg >= month_start(4'(i)))
            begin
                mon_next = 4'(i);
            end
        end
        day_full = s7_doy_reg - month_start(mon_next) + 9'd1;
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            s8_yr_reg  <= s7_yr_reg;
            s8_mon_reg <= mon_next;
            s8_day_reg <= day_full[4:0];
        end
    end

    assign year  = s8_yr_reg;
    assign month = s8_mon_reg;
    assign day   = s8_day_reg;

endmodule

/* rtl/core/dnd_to_days.sv */
// Year, month and day to day count datapath, five stages and a delay line.
module dnd_to_days import dnd_pkg::*;
(
    input  logic            clk,
    input  logic [NSTG-1:0] en,
    input  logic [22:0]     in_year,
    input  logic [3:0]      in_month,
    input  logic [4:0]      in_day,
    output logic [30:0]     day_count
);

    localparam int DLY = NSTG - DAYS_STG;

    // Stage 0: month offset plus day, 365 * year, and (year - 1) / 4.
    logic [22:0] pm1;
    logic [3:0]  msat;
    logic [31:0] y365_full;
    logic        s0_yzero_reg;
    logic [1:0]  s0_ylo_reg;
    logic [20:0] s0_a_reg;
    logic [8:0]  s0_dd_reg;
    logic [30:0] s0_y365_reg;

    always_comb
    begin
        pm1       = in_year - 23'd1;
        msat      = (in_month > MONTH_LAST) ? MONTH_LAST : in_month;
        y365_full = {9'd0, in_year} * 32'(DAYS_COMMON);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_yzero_reg <= (in_year == 23'd0);
            s0_ylo_reg   <= in_year[1:0];
            s0_a_reg     <= pm1[22:2];
            s0_dd_reg    <= month_start(msat) + {4'd0, in_day};
            s0_y365_reg  <= y365_full[30:0];
        end
    end

    // Stage 1: (year - 1) / 100 as ((year - 1) / 4) / 25.
    logic [42:0] prod25;
    logic [16:0] s1_b_reg;
    logic        s1_yzero_reg;
    logic [1:0]  s1_ylo_reg;
    logic [20:0] s1_a_reg;
    logic [8:0]  s1_dd_reg;
    logic [30:0] s1_y365_reg;

    assign prod25 = {22'd0, s0_a_reg} * {21'd0, RECIP_25};

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_b_reg     <= prod25[42:RECIP_25_SH];
            s1_yzero_reg <= s0_yzero_reg;
            s1_ylo_reg   <= s0_ylo_reg;
            s1_a_reg     <= s0_a_reg;
            s1_dd_reg    <= s0_dd_reg;
            s1_y365_reg  <= s0_y365_reg;
        end
    end

    // Stage 2: leap year test. For a year divisible by four, it is a century
    // exactly when (year - 1) / 4 leaves 24 modulo 25, and then a 400-year
    // boundary when (year - 1) / 100 leaves 3 modulo 4.
    logic        hund;
    logic        s2_leap_reg;
    logic        s2_yzero_reg;
    logic [20:0] s2_a_reg;
    logic [16:0] s2_b_reg;
    logic [8:0]  s2_dd_reg;
    logic [30:0] s2_y365_reg;

    assign hund = ({1'b0, s1_a_reg} == ({5'd0, s1_b_reg} * 22'd25 + 22'd24));

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_leap_reg  <= s1_yzero_reg
                            || ((s1_ylo_reg == 2'd0) && (!hund || (s1_b_reg[1:0] == 2'd3)));
            s2_yzero_reg <= s1_yzero_reg;
            s2_a_reg     <= s1_a_reg;
            s2_b_reg     <= s1_b_reg;
            s2_dd_reg    <= s1_dd_reg;
            s2_y365_reg  <= s1_y365_reg;
        end
    end

    // Stage 3: days before the year, minus one, which cancels the one taken
    // from the day of month. Year 0 starts at day 0.
    logic [30:0] base_m1_next;
    logic [8:0]  off_next;
    logic [30:0] s3_base_reg;
    logic [8:0]  s3_off_reg;

    always_comb
    begin
        if (s2_yzero_reg)
        begin
            base_m1_next = '1;
        end
        else
        begin
            base_m1_next = s2_y365_reg + {10'd0, s2_a_reg} - {14'd0, s2_b_reg}
                           + {16'd0, s2_b_reg[16:2]};
        end
        off_next = s2_dd_reg - {8'd0, (!s2_leap_reg && (s2_dd_reg >= 9'(MARCH_DD)))};
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_base_reg <= base_m1_next;
            s3_off_reg  <= off_next;
        end
    end

    // Stage 4 computes the count; the delay line keeps it in step with the
    // date datapath.
    logic [30:0] total_reg [DLY];

    always_ff @(posedge clk)
    begin
        if (en[DAYS_STG])
        begin
            total_reg[0] <= s3_base_reg + {22'd0, s3_off_reg};
        end
        for (int i = 1; i < DLY; i++)
        begin
            if (en[DAYS_STG + i])
            begin
                total_reg[i] <= total_reg[i-1];
            end
        end
    end

    assign day_count = total_reg[DLY-1];

endmodule

/* rtl/core/day_number_date_converter.sv */
// Top level of the day count / proleptic Gregorian date converter.
// Each request carries a command: to-date splits day_count (day 0 is 1 January
// of year 0) into out_year, out_month (0 is January) and out_day; to-days turns
// in_year, in_month and in_day into out_day_count, modulo 2^31, with months above
// December taken as December and the day not checked. Fields of the other
// command read as zero. The block is a nine-stage pipeline, and one request can
// be accepted every cycle while req_stall is low. Stages without a valid item
// absorb a stall, so req_stall is only raised when res_stall holds back a full
// pipeline. The longest stage is the reciprocal multiply that splits the day
// count into 400-year cycles.
module day_number_date_converter import dnd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  dnd_req_t req,
    output logic     res_valid,
    input  logic     res_stall,
    output dnd_res_t res
);

    logic [NSTG-1:0] en;
    logic            res_cmd;
    logic [22:0]     date_year;
    logic [3:0]      date_month;
    logic [4:0]      date_day;
    logic [30:0]     days_count;

    dnd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (req.command),
        .res_stall (res_stall),
        .req_stall (req_stall),
        .en        (en),
        .res_valid (res_valid),
        .res_cmd   (res_cmd)
    );

    dnd_to_date u_to_date (
        .clk       (clk),
        .en        (en),
        .day_count (req.day_count),
        .year      (date_year),
        .month     (date_month),
        .day       (date_day)
    );

    dnd_to_days u_to_days (
        .clk       (clk),
        .en        (en),
        .in_year   (req.in_year),
        .in_month  (req.in_month),
        .in_day    (req.in_day),
        .day_count (days_count)
    );

    always_comb
    begin
        if (res_cmd == CMD_TO_DAYS)
        begin
            res.out_year      = '0;
            res.out_month     = '0;
            res.out_day       = '0;
            res.out_day_count = days_count;
        end
        else
        begin
            res.out_year      = date_year;
            res.out_month     = date_month;
            res.out_day       = date_day;
            res.out_day_count = '0;
        end
    end

endmodule

/* rtl/core/dnd_checker.sv */
// Port-level checks of the day number / date converter and their binding.
module dnd_checker import dnd_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_stall,
    input dnd_req_t req,
    input logic     res_valid,
    input logic     res_stall,
    input dnd_res_t res
);

    // The pipeline only pushes back on requests when the result side stalls.
    a_stall_origin: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> res_stall)
        else $error("request stalled without a result stall");

    // A date result has a nonzero day and no day count; a day count result
    // has no date fields.
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res.out_day != 5'd0) ? (res.out_day_count == 31'd0)
                       : ((res.out_year == 23'd0) && (res.out_month == 4'd0))))
        else $error("result mixes date and day count fields");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.out_month <= MONTH_LAST))
        else $error("result month out of range");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed or dropped");

endmodule

bind day_number_date_converter dnd_checker u_dnd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
